[rtl/core/jbhd_pkg.sv]
// ----------------------------------------------------------------------------
// jbhd_pkg
// shared types, result codes and standard huffman tables for the decoder
// ----------------------------------------------------------------------------
package jbhd_pkg;

  localparam int BLOCK_COEFFS   = 64;
  localparam int MAX_CODE_LEN   = 16;
  localparam int COMP_COUNT     = 3;
  localparam int DC_NVALS       = 12;
  localparam int AC_NVALS       = 162;

  // result kinds
  localparam logic [1:0] KIND_COEFF  = 2'd0;
  localparam logic [1:0] KIND_EOB    = 2'd1;
  localparam logic [1:0] KIND_MARKER = 2'd2;

  // request types
  localparam logic REQ_DATA    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // table selectors
  localparam logic [1:0] TBL_DC_LUM = 2'd0;
  localparam logic [1:0] TBL_DC_CHR = 2'd1;
  localparam logic [1:0] TBL_AC_LUM = 2'd2;
  localparam logic [1:0] TBL_AC_CHR = 2'd3;

  localparam logic [7:0] BYTE_FF = 8'hFF;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic [1:0] component;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [5:0]         coeff_index;
    logic signed [15:0] coeff_value;
    logic [7:0]         marker_code;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_EOB,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic restart;
    logic load;
    logic step;
    logic eob;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic feed;
    logic marker;
    logic can_push;
    logic eob_after;
  } dp_stat_t;

  typedef logic [17:0] code_tab_t [16];

  // code counts per length for each table
  localparam logic [7:0] BITS_TAB [4][16] = '{
    '{8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
      8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d},
    '{8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
      8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77}
  };

  localparam logic [7:0] AC_LUM_VALS [AC_NVALS] = '{
    8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12,
    8'h21, 8'h31, 8'h41, 8'h06, 8'h13, 8'h51, 8'h61, 8'h07,
    8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'ha1, 8'h08,
    8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0,
    8'h24, 8'h33, 8'h62, 8'h72, 8'h82, 8'h09, 8'h0a, 8'h16,
    8'h17, 8'h18, 8'h19, 8'h1a, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h29, 8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h3a, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
    8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
    8'h6a, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79,
    8'h7a, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
    8'h99, 8'h9a, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7,
    8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6,
    8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5,
    8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4,
    8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1, 8'he2,
    8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea,
    8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8,
    8'hf9, 8'hfa
  };

  localparam logic [7:0] AC_CHR_VALS [AC_NVALS] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04, 8'h05, 8'h21,
    8'h31, 8'h06, 8'h12, 8'h41, 8'h51, 8'h07, 8'h61, 8'h71,
    8'h13, 8'h22, 8'h32, 8'h81, 8'h08, 8'h14, 8'h42, 8'h91,
    8'ha1, 8'hb1, 8'hc1, 8'h09, 8'h23, 8'h33, 8'h52, 8'hf0,
    8'h15, 8'h62, 8'h72, 8'hd1, 8'h0a, 8'h16, 8'h24, 8'h34,
    8'he1, 8'h25, 8'hf1, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h2a, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h3a, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
    8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
    8'h59, 8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68,
    8'h69, 8'h6a, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
    8'h79, 8'h7a, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h88, 8'h89, 8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
    8'h97, 8'h98, 8'h99, 8'h9a, 8'ha2, 8'ha3, 8'ha4, 8'ha5,
    8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4,
    8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3,
    8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hd2,
    8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda,
    8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9,
    8'hea, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8,
    8'hf9, 8'hfa
  };

  // first canonical code of each length
  function automatic code_tab_t calc_first(int t);
    logic [17:0] f;
    code_tab_t   r;
    f = '0;
    for (int l = 0; l < MAX_CODE_LEN; l++) begin
      r[l] = f;
      f    = (f + 18'(BITS_TAB[t][l])) << 1;
    end
    return r;
  endfunction

  // symbol index of the first code of each length
  function automatic code_tab_t calc_base(int t);
    logic [17:0] b;
    code_tab_t   r;
    b = '0;
    for (int l = 0; l < MAX_CODE_LEN; l++) begin
      r[l] = b;
      b    = b + 18'(BITS_TAB[t][l]);
    end
    return r;
  endfunction

  localparam code_tab_t FIRST_TAB [4] = '{
    calc_first(0), calc_first(1), calc_first(2), calc_first(3)
  };
  localparam code_tab_t BASE_TAB [4] = '{
    calc_base(0), calc_base(1), calc_base(2), calc_base(3)
  };

endpackage

[rtl/core/jpeg_baseline_huffman_decoder.sv]
// ----------------------------------------------------------------------------
// jpeg_baseline_huffman_decoder
// baseline jpeg huffman symbol decoder with the standard tables
// ----------------------------------------------------------------------------
// throughput: a data byte is loaded, then decoded one bit per cycle while results
//   can be pushed, with a block end step after a coefficient that ends a block on
//   the same bit, then a flush; no new byte is taken until the flush is done
// results wait in a hold register for the next result or the flush that ends the item
// restart, lone ff and halted bytes are taken in idle with no bit steps or flush
// reset: synchronous active-low rst_n clears predictors, position and halt
// ----------------------------------------------------------------------------
module jpeg_baseline_huffman_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jbhd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output jbhd_pkg::out_item_t out_data
);
  import jbhd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  jbhd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  // datapath
  jbhd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/jbhd_ctrl.sv]
// ----------------------------------------------------------------------------
// jbhd_ctrl
// sequencer: takes items, steps a bit per cycle unless stalled, flushes results
// ----------------------------------------------------------------------------
module jbhd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_req_type,
  output logic               in_stall,
  input  jbhd_pkg::dp_stat_t stat,
  output jbhd_pkg::dp_cmd_t  cmd
);
  import jbhd_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && in_req_type == REQ_DATA) begin
          if (stat.feed) begin
            state_nxt = ST_BITS;
          end else if (stat.marker) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_BITS: begin
        if (stat.can_push) begin
          cnt_nxt = cnt_r + 4'd1;
          if (stat.eob_after) begin
            state_nxt = ST_EOB;
          end else if (cnt_r == 4'd7) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_EOB: begin
        if (stat.can_push) begin
          state_nxt = (cnt_r == 4'd8) ? ST_FLUSH : ST_BITS;
        end
      end
      ST_FLUSH: begin
        if (stat.can_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd         = '0;
    cmd.restart = accept && (in_req_type == REQ_RESTART);
    cmd.load    = accept && (in_req_type == REQ_DATA);
    cmd.step    = (state_r == ST_BITS) && stat.can_push;
    cmd.eob     = (state_r == ST_EOB) && stat.can_push;
    cmd.flush   = (state_r == ST_FLUSH) && stat.can_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[rtl/core/jbhd_dp.sv]
// ----------------------------------------------------------------------------
// jbhd_dp
// datapath: byte unstuffing, bit-serial code match, value build, result regs
// ----------------------------------------------------------------------------
module jbhd_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  jbhd_pkg::in_item_t  in_data,
  input  jbhd_pkg::dp_cmd_t   cmd,
  output jbhd_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output jbhd_pkg::out_item_t out_data
);
  import jbhd_pkg::*;

  // decode state
  logic [16:0] pc_r, pc_nxt;
  logic [4:0]  cl_r, cl_nxt;
  logic [3:0]  ps_r, ps_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [1:0]  bc_r, bc_nxt;
  logic [15:0] pred_r [COMP_COUNT];
  logic        saw_ff_r, halted_r;
  logic [7:0]  shift_r;
  logic [1:0]  comp_r;

  // result registers
  out_item_t hold_r, out_r, out_nxt;
  logic      hold_valid_r, out_valid_r;

  // step results
  logic        new_v, eob_after;
  out_item_t   new_res;
  logic        pred_we;
  logic [15:0] pred_val;

  // lookup signals
  logic        bit_in, is_dc, fin;
  logic [15:0] fin_val;
  logic [1:0]  tbl, comp_clamp;
  logic [3:0]  li;
  logic [17:0] code, first, base, idx, cnt;
  logic [7:0]  sym;
  logic        matched;
  logic [16:0] half;
  logic [15:0] mag_off;

  assign bit_in     = shift_r[7];
  assign comp_clamp = (comp_r >= 2'(COMP_COUNT)) ? 2'(COMP_COUNT - 1) : comp_r;

  // input byte classification
  always_comb begin
    stat.feed   = !halted_r && (saw_ff_r ? (in_data.data_byte == 8'd0)
                                         : (in_data.data_byte != BYTE_FF));
    stat.marker = !halted_r && saw_ff_r && (in_data.data_byte != 8'd0);
    stat.can_push  = !hold_valid_r || !out_valid_r || !out_stall;
    stat.eob_after = eob_after;
  end

  // one bit of decoding
  always_comb begin
    pc_nxt    = {pc_r[15:0], bit_in};
    cl_nxt    = cl_r + 5'd1;
    ps_nxt    = ps_r;
    pos_nxt   = pos_r;
    bc_nxt    = bc_r;
    new_v     = 1'b0;
    new_res   = '0;
    eob_after = 1'b0;
    pred_we   = 1'b0;
    pred_val  = '0;
    fin       = 1'b0;
    fin_val   = '0;
    is_dc     = (pos_r == 7'd0);
    tbl       = TBL_DC_LUM;
    li        = '0;
    code      = 18'(pc_nxt);
    first     = '0;
    base      = '0;
    cnt       = '0;
    idx       = '0;
    sym       = '0;
    matched   = 1'b0;
    half      = 17'd1 << (ps_r - 4'd1);
    mag_off   = (16'd1 << ps_r) - 16'd1;

    if (ps_r != 4'd0) begin
      // magnitude bits
      if (cl_nxt >= 5'(ps_r)) begin
        fin     = 1'b1;
        fin_val = (pc_nxt < half) ? (pc_nxt[15:0] - mag_off) : pc_nxt[15:0];
        pc_nxt  = '0;
        cl_nxt  = '0;
        ps_nxt  = '0;
      end
    end else begin
      if (is_dc && cl_r == 5'd0) begin
        bc_nxt = comp_clamp;
      end
      tbl = is_dc ? ((bc_nxt == 2'd0) ? TBL_DC_LUM : TBL_DC_CHR)
                  : ((bc_nxt == 2'd0) ? TBL_AC_LUM : TBL_AC_CHR);
      if (cl_nxt <= 5'(MAX_CODE_LEN)) begin
        li    = 4'(cl_nxt - 5'd1);
        first = FIRST_TAB[tbl][li];
        base  = BASE_TAB[tbl][li];
        cnt   = 18'(BITS_TAB[tbl][li]);
        if (cnt != 18'd0 && code < first + cnt) begin
          matched = 1'b1;
          if (code >= first) begin
            idx = base + code - first;
            if (is_dc) begin
              sym = (idx < 18'(DC_NVALS)) ? idx[7:0] : 8'd0;
            end else if (idx < 18'(AC_NVALS)) begin
              sym = (tbl == TBL_AC_LUM) ? AC_LUM_VALS[idx[7:0]] : AC_CHR_VALS[idx[7:0]];
            end
          end
        end
      end else begin
        // overlong code decodes as symbol zero
        matched = 1'b1;
      end
      if (matched) begin
        pc_nxt = '0;
        cl_nxt = '0;
        if (is_dc) begin
          if (sym[3:0] == 4'd0) begin
            fin = 1'b1;
          end else begin
            ps_nxt = sym[3:0];
          end
        end else if (sym[3:0] != 4'd0) begin
          pos_nxt = pos_r + 7'(sym[7:4]);
          ps_nxt  = sym[3:0];
        end else if (sym[7:4] == 4'd15) begin
          pos_nxt = pos_r + 7'd16;
          if (pos_nxt >= 7'(BLOCK_COEFFS)) begin
            pos_nxt             = '0;
            new_v               = 1'b1;
            new_res.result_kind = KIND_EOB;
          end
        end else begin
          pos_nxt             = '0;
          new_v               = 1'b1;
          new_res.result_kind = KIND_EOB;
        end
      end
    end

    // finished value: dc sum or ac coefficient
    if (fin) begin
      if (pos_r == 7'd0) begin
        pred_we             = 1'b1;
        pred_val            = pred_r[bc_nxt] + fin_val;
        new_v               = 1'b1;
        new_res.result_kind = KIND_COEFF;
        new_res.coeff_value = pred_val;
        pos_nxt             = 7'd1;
      end else begin
        if (pos_r < 7'(BLOCK_COEFFS)) begin
          new_v               = 1'b1;
          new_res.result_kind = KIND_COEFF;
          new_res.coeff_index = pos_r[5:0];
          new_res.coeff_value = fin_val;
        end
        pos_nxt = pos_r + 7'd1;
        if (pos_nxt >= 7'(BLOCK_COEFFS)) begin
          pos_nxt = '0;
          if (new_v) begin
            eob_after = 1'b1;
          end else begin
            new_v               = 1'b1;
            new_res.result_kind = KIND_EOB;
          end
        end
      end
    end
  end

  // result push
  logic      push_v, to_out;
  out_item_t push_res, eob_res, mk_res;

  always_comb begin
    eob_res             = '0;
    eob_res.result_kind = KIND_EOB;
    mk_res              = '0;
    mk_res.result_kind  = KIND_MARKER;
    mk_res.marker_code  = in_data.data_byte;
    push_v   = (cmd.step && new_v) || cmd.eob;
    push_res = cmd.eob ? eob_res : new_res;
    to_out   = hold_valid_r && (push_v || cmd.flush);
  end

  // output item, last flag set on the flush
  always_comb begin
    out_nxt             = hold_r;
    out_nxt.last_of_run = cmd.flush;
  end

  // decode state registers
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      pc_r     <= '0;
      cl_r     <= '0;
      ps_r     <= '0;
      pos_r    <= '0;
      bc_r     <= '0;
      saw_ff_r <= 1'b0;
      halted_r <= 1'b0;
      for (int i = 0; i < COMP_COUNT; i++) begin
        pred_r[i] <= '0;
      end
    end else if (cmd.load) begin
      if (!halted_r) begin
        if (saw_ff_r) begin
          saw_ff_r <= 1'b0;
          if (in_data.data_byte != 8'd0) begin
            halted_r <= 1'b1;
            pc_r     <= '0;
            cl_r     <= '0;
            ps_r     <= '0;
          end
        end else if (in_data.data_byte == BYTE_FF) begin
          saw_ff_r <= 1'b1;
        end
      end
    end else if (cmd.step) begin
      pc_r  <= pc_nxt;
      cl_r  <= cl_nxt;
      ps_r  <= ps_nxt;
      pos_r <= pos_nxt;
      bc_r  <= bc_nxt;
      if (pred_we) begin
        pred_r[bc_nxt] <= pred_val;
      end
    end
  end

  // byte shifter and sampled component
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shift_r <= saw_ff_r ? BYTE_FF : in_data.data_byte;
      comp_r  <= in_data.component;
    end else if (cmd.step) begin
      shift_r <= {shift_r[6:0], 1'b0};
    end
  end

  // hold and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (to_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (push_v || (cmd.load && stat.marker)) begin
        hold_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (to_out) begin
      out_r <= out_nxt;
    end
    if (push_v) begin
      hold_r <= push_res;
    end else if (cmd.load && stat.marker) begin
      hold_r <= mk_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[sim/jbhd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jbhd_checker
// watches both channels of the huffman decoder, predicts every result from
// the accepted input items and compares the results field by field
// ----------------------------------------------------------------------------
module jbhd_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  jbhd_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  jbhd_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);
  import jbhd_pkg::*;

  // decoder state mirror
  logic [15:0] dc_pred [COMP_COUNT];
  int unsigned zz_pos;
  int unsigned blk_comp;
  logic [16:0] code_acc;
  int unsigned code_len;
  int unsigned mag_size;
  logic        ff_seen;
  logic        stopped;

  out_item_t coeff_queue [$];
  out_item_t step_items [$];

  function automatic void clear_decoder();
    for (int i = 0; i < COMP_COUNT; i++) dc_pred[i] = '0;
    zz_pos = 0; blk_comp = 0; code_acc = '0; code_len = 0; mag_size = 0;
    ff_seen = 1'b0; stopped = 1'b0;
  endfunction

  function automatic void push_item(logic [1:0] kind, logic [5:0] idx, logic [15:0] val,
                                    logic [7:0] mk);
    out_item_t it;
    it.result_kind = kind; it.coeff_index = idx; it.coeff_value = val;
    it.marker_code = mk; it.last_of_run = 1'b0;
    step_items.push_back(it);
  endfunction

  // canonical lookup: -1 incomplete, else symbol
  function automatic int huff_symbol(int t, int unsigned len, int unsigned code);
    int unsigned first, base, cnt, idx;
    first = 0; base = 0;
    for (int unsigned l = 1; l < len; l++) begin
      first = (first + BITS_TAB[t][l-1]) << 1;
      base += BITS_TAB[t][l-1];
    end
    cnt = BITS_TAB[t][len-1];
    if (cnt == 0 || code >= first + cnt) return -1;
    if (code < first) return 0;
    idx = base + (code - first);
    if (t == TBL_DC_LUM || t == TBL_DC_CHR) begin
      if (idx >= DC_NVALS) return 0;
      return idx;
    end
    if (idx > 255 || idx >= AC_NVALS) return 0;
    return (t == TBL_AC_LUM) ? AC_LUM_VALS[idx] : AC_CHR_VALS[idx];
  endfunction

  function automatic void close_block();
    push_item(KIND_EOB, '0, '0, '0);
    zz_pos = 0;
  endfunction

  function automatic void land_value(int v);
    logic [15:0] p;
    if (zz_pos == 0) begin
      p = dc_pred[blk_comp] + 16'(v);
      dc_pred[blk_comp] = p;
      push_item(KIND_COEFF, '0, p, '0);
      zz_pos = 1;
      return;
    end
    if (zz_pos < BLOCK_COEFFS) push_item(KIND_COEFF, 6'(zz_pos), 16'(v), '0);
    zz_pos++;
    if (zz_pos >= BLOCK_COEFFS) close_block();
  endfunction

  function automatic void decode_bit(logic b, logic [1:0] comp);
    int sym, v;
    int unsigned s, r;
    logic dc, lum;
    if (mag_size != 0) begin
      code_acc = {code_acc[15:0], b};
      code_len++;
      if (code_len >= mag_size) begin
        v = int'(code_acc);
        if (code_acc < (17'd1 << (mag_size - 1))) v -= (1 << mag_size) - 1;
        code_acc = '0; code_len = 0; mag_size = 0;
        land_value(v);
      end
      return;
    end
    if (zz_pos == 0 && code_len == 0)
      blk_comp = (comp >= COMP_COUNT) ? COMP_COUNT - 1 : comp;
    code_acc = {code_acc[15:0], b};
    code_len++;
    dc = (zz_pos == 0);
    lum = (blk_comp == 0);
    if (code_len <= MAX_CODE_LEN) begin
      if (dc) sym = huff_symbol(lum ? TBL_DC_LUM : TBL_DC_CHR, code_len, code_acc);
      else    sym = huff_symbol(lum ? TBL_AC_LUM : TBL_AC_CHR, code_len, code_acc);
      if (sym < 0) return;
    end else sym = 0;
    code_acc = '0; code_len = 0;
    s = sym & 15;
    r = (sym >> 4) & 15;
    if (dc) begin
      if (s == 0) land_value(0);
      else mag_size = s;
      return;
    end
    if (s != 0) begin
      zz_pos += r; mag_size = s;
    end else if (r == 15) begin
      zz_pos += 16;
      if (zz_pos >= BLOCK_COEFFS) close_block();
    end else close_block();
  endfunction

  function automatic void predict_item(in_item_t it);
    logic [7:0] byte_v;
    step_items.delete();
    if (it.req_type == REQ_RESTART) begin
      clear_decoder();
      return;
    end
    if (stopped) return;
    byte_v = it.data_byte;
    if (ff_seen) begin
      ff_seen = 1'b0;
      if (byte_v != 0) begin
        stopped = 1'b1; code_acc = '0; code_len = 0; mag_size = 0;
        push_item(KIND_MARKER, '0, '0, byte_v);
      end else byte_v = BYTE_FF;
    end else if (byte_v == BYTE_FF) begin
      ff_seen = 1'b1;
      return;
    end
    if (!stopped)
      for (int i = 7; i >= 0; i--) decode_bit(byte_v[i], it.component);
    if (step_items.size() > 0) step_items[$].last_of_run = 1'b1;
    foreach (step_items[i]) coeff_queue.push_back(step_items[i]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // predict on input acceptance, compare on result acceptance
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_decoder();
      coeff_queue.delete();
      fail_count = 0;
      pending_count <= 0;
    end else begin
      if (in_valid && !in_stall) predict_item(in_data);
      if (out_valid && !out_stall) begin
        if (coeff_queue.size() == 0) begin
          report_mismatch("unexpected result kind", out_data.result_kind, -1);
        end else begin
          want = coeff_queue.pop_front();
          if (out_data.result_kind !== want.result_kind)
            report_mismatch("result_kind", out_data.result_kind, want.result_kind);
          if (out_data.coeff_index !== want.coeff_index)
            report_mismatch("coeff_index", out_data.coeff_index, want.coeff_index);
          if (out_data.coeff_value !== want.coeff_value)
            report_mismatch("coeff_value", out_data.coeff_value, want.coeff_value);
          if (out_data.marker_code !== want.marker_code)
            report_mismatch("marker_code", out_data.marker_code, want.marker_code);
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", out_data.last_of_run, want.last_of_run);
        end
      end
      pending_count <= coeff_queue.size();
    end
  end

endmodule

[sim/tb_jpeg_baseline_huffman_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_jpeg_baseline_huffman_decoder
// drives scan bytes, restarts and markers into the decoder with random gaps
// and result stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_jpeg_baseline_huffman_decoder;
  import jbhd_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending_count;
  int        idle_cycles;
  logic      stall_on;

  jpeg_baseline_huffman_decoder u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  jbhd_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending_count
  );

  // clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // result side stall pattern, with quiet stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_on  <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_on <= !stall_on;
      if (stall_on) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 :
                        ($urandom_range(0, 60) == 0) ? 1'b1 : 1'b0;
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // valid stays high into the next item when there is no gap
  task automatic send_item(logic req, logic [7:0] b, logic [1:0] comp);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: req, data_byte: b, component: comp};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_data(logic [7:0] b, logic [1:0] comp);
    send_item(REQ_DATA, b, comp);
    if (b == BYTE_FF) send_item(REQ_DATA, 8'h00, comp);
  endtask

  task automatic send_restart();
    send_item(REQ_RESTART, 8'($urandom), 2'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int sent;
    int pick;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zeros, ones, stuffing, lone ff, markers, restarts, components
    send_data(8'h00, 2'd0);
    send_data(8'h00, 2'd1);
    send_data(8'hFF, 2'd2);
    send_data(8'hFF, 2'd3);
    send_data(8'hFE, 2'd0);
    send_data(8'h55, 2'd1);
    send_data(8'hAA, 2'd2);
    send_item(REQ_DATA, 8'hFF, 2'd0);
    send_item(REQ_DATA, 8'hD0, 2'd0);
    send_data(8'h12, 2'd0);
    send_restart();
    send_data(8'h3C, 2'd3);
    send_item(REQ_DATA, 8'hFF, 2'd1);
    send_item(REQ_DATA, 8'hFF, 2'd1);
    send_restart();
    send_data(8'h01, 2'd0);
    send_data(8'h80, 2'd1);
    send_data(8'h7F, 2'd2);
    drain_results();

    // random: mostly clean stuffed data, some markers and restarts
    sent = 0;
    while (sent < 370) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_restart();
      end else if (pick < 4) begin
        send_item(REQ_DATA, 8'hFF, 2'($urandom));
        send_item(REQ_DATA, 8'($urandom_range(1, 255)), 2'($urandom));
        send_restart();
      end else if (pick < 10) begin
        send_item(REQ_DATA, 8'($urandom), 2'($urandom));
      end else if (pick < 25) begin
        send_data(8'($urandom_range(0, 3)), 2'($urandom));
      end else begin
        send_data(8'($urandom), 2'($urandom_range(0, 2)));
      end
      sent++;
      if (sent % 120 == 0) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/jbhd_pkg.sv
rtl/core/jbhd_ctrl.sv
rtl/core/jbhd_dp.sv
rtl/core/jpeg_baseline_huffman_decoder.sv
sim/jbhd_checker.sv
sim/tb_jpeg_baseline_huffman_decoder.sv
